### rtl/core/wsdm_pkg.sv
// Package for the window shape descriptor match block.
// Holds sizes, status codes, sequencer states, datapath operations and the
// command and status structs. Depends on nothing.
package wsdm_pkg;

    localparam int P          = 17;                  // descriptor points
    localparam int D          = P - 1;
    localparam int MAX_WINDOW = 64;
    localparam int AW         = $clog2(MAX_WINDOW);  // sample memory address
    localparam int CW         = $clog2(MAX_WINDOW + 1);
    localparam int IW         = $clog2(P);
    localparam int RW         = $clog2(D + 1);       // interpolation weight
    localparam int SW         = 24;                  // sample width
    localparam int SUMW       = SW + AW;
    localparam int KW         = 2 * CW + 1;
    localparam int NEW        = SW + 1 + CW + RW;
    localparam int PW         = SW + RW + 1;         // weighted sample product
    localparam int WW         = 44;                  // residual width
    localparam int QW         = 16;                  // descriptor width
    localparam int BW         = $clog2(QW);
    localparam int LW         = 17;                  // match limit width
    localparam int ACCW       = 2 * QW + IW;
    localparam int LIMW       = LW + IW + QW;

    localparam logic [LW-1:0] LIMIT_RESET = LW'(6554);

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FLAT  = 2'd1;
    localparam logic [1:0] STAT_SHORT = 2'd2;
    localparam logic [1:0] STAT_LONG  = 2'd3;

    typedef enum logic [3:0] {
        S_COLLECT, S_CHECK, S_PREP, S_RDA, S_RDB, S_MUL1, S_MUL2, S_WRW,
        S_RANGE, S_NINIT, S_NSTEP, S_SQ, S_ACC, S_MATCH, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_STORE, OP_CHECK, OP_PREP, OP_RDA, OP_RDB, OP_MUL1, OP_MUL2,
        OP_WRW, OP_RANGE, OP_NINIT, OP_NSTEP, OP_SQ, OP_ACC, OP_MATCH, OP_OUTW
    } t_op;

    typedef struct packed {
        t_op           op;
        logic [IW-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic cut;   // window too long or too short
        logic flat;  // all residuals equal
    } t_sts;

endpackage

### rtl/core/wsdm_ctrl.sv
// Sequencer for the window shape descriptor match block.
// Walks collection, per-point residuals, normalization, match and output.
// Depends on wsdm_pkg.
module wsdm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_last_sample,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  wsdm_pkg::t_sts    i_sts,
    output wsdm_pkg::t_cmd    o_cmd
);

    wsdm_pkg::t_state                 r_state, n_state;
    logic [wsdm_pkg::IW-1:0]          r_idx, n_idx;
    logic [wsdm_pkg::BW-1:0]          r_bit, n_bit;
    logic                             w_idx_last;

    assign w_idx_last = (r_idx == wsdm_pkg::IW'(wsdm_pkg::P - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsdm_pkg::S_COLLECT;
            r_idx   <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_bit      = r_bit;
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        o_cmd.op   = wsdm_pkg::OP_NONE;
        o_cmd.idx  = r_idx;
        case (r_state)
            wsdm_pkg::S_COLLECT: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = wsdm_pkg::OP_STORE;
                    if (i_last_sample) n_state = wsdm_pkg::S_CHECK;
                end
            end
            wsdm_pkg::S_CHECK: begin
                o_cmd.op = wsdm_pkg::OP_CHECK;
                n_idx    = '0;
                n_state  = i_sts.cut ? wsdm_pkg::S_OUT : wsdm_pkg::S_PREP;
            end
            wsdm_pkg::S_PREP: begin
                o_cmd.op = wsdm_pkg::OP_PREP;
                n_state  = wsdm_pkg::S_RDA;
            end
            wsdm_pkg::S_RDA: begin
                o_cmd.op = wsdm_pkg::OP_RDA;
                n_state  = wsdm_pkg::S_RDB;
            end
            wsdm_pkg::S_RDB: begin
                o_cmd.op = wsdm_pkg::OP_RDB;
                n_state  = wsdm_pkg::S_MUL1;
            end
            wsdm_pkg::S_MUL1: begin
                o_cmd.op = wsdm_pkg::OP_MUL1;
                n_state  = wsdm_pkg::S_MUL2;
            end
            wsdm_pkg::S_MUL2: begin
                o_cmd.op = wsdm_pkg::OP_MUL2;
                n_state  = wsdm_pkg::S_WRW;
            end
            wsdm_pkg::S_WRW: begin
                o_cmd.op = wsdm_pkg::OP_WRW;
                if (w_idx_last) begin
                    n_idx   = '0;
                    n_state = wsdm_pkg::S_RANGE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = wsdm_pkg::S_RDA;
                end
            end
            wsdm_pkg::S_RANGE: begin
                o_cmd.op = wsdm_pkg::OP_RANGE;
                n_state  = i_sts.flat ? wsdm_pkg::S_OUT : wsdm_pkg::S_NINIT;
            end
            wsdm_pkg::S_NINIT: begin
                o_cmd.op = wsdm_pkg::OP_NINIT;
                n_bit    = '0;
                n_state  = wsdm_pkg::S_NSTEP;
            end
            wsdm_pkg::S_NSTEP: begin
                o_cmd.op = wsdm_pkg::OP_NSTEP;
                n_bit    = r_bit + 1'b1;
                if (r_bit == wsdm_pkg::BW'(wsdm_pkg::QW - 1)) n_state = wsdm_pkg::S_SQ;
            end
            wsdm_pkg::S_SQ: begin
                o_cmd.op = wsdm_pkg::OP_SQ;
                n_state  = wsdm_pkg::S_ACC;
            end
            wsdm_pkg::S_ACC: begin
                o_cmd.op = wsdm_pkg::OP_ACC;
                if (w_idx_last) begin
                    n_idx   = '0;
                    n_state = wsdm_pkg::S_MATCH;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = wsdm_pkg::S_NINIT;
                end
            end
            wsdm_pkg::S_MATCH: begin
                o_cmd.op = wsdm_pkg::OP_MATCH;
                n_state  = wsdm_pkg::S_OUT;
            end
            wsdm_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    o_cmd.op = wsdm_pkg::OP_OUTW;
                    if (w_idx_last) begin
                        n_idx   = '0;
                        n_state = wsdm_pkg::S_COLLECT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = wsdm_pkg::S_COLLECT;
            end
        endcase
    end

endmodule

### rtl/core/wsdm_dp.sv
// Datapath for the window shape descriptor match block: sample memory,
// residual arithmetic, bit-serial normalizer, match accumulator, reference.
// Depends on wsdm_pkg.
module wsdm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wsdm_pkg::t_cmd                i_cmd,
    output wsdm_pkg::t_sts                o_sts,
    input  logic signed [wsdm_pkg::SW-1:0] i_sample,
    input  logic                          i_keep_reference,
    input  logic                          i_cfg_we,
    input  logic [wsdm_pkg::LW-1:0]       i_cfg_data,
    output logic [wsdm_pkg::QW-1:0]       o_descriptor,
    output logic [4:0]                    o_position,
    output logic                          o_last_of_run,
    output logic [1:0]                    o_status,
    output logic                          o_match,
    output logic                          o_match_valid
);

    logic signed [wsdm_pkg::SW-1:0]   mem [wsdm_pkg::MAX_WINDOW];
    logic signed [wsdm_pkg::SW-1:0]   r_rd;
    logic [wsdm_pkg::CW-1:0]          r_count;
    logic                             r_ovf;
    logic                             r_keep;
    logic signed [wsdm_pkg::SUMW-1:0] r_sum;
    logic signed [wsdm_pkg::SW-1:0]   r_first, r_lastx, r_xa;
    logic [wsdm_pkg::KW-1:0]          r_k1;
    logic signed [wsdm_pkg::WW-1:0]   r_c2, r_pk, r_t3, r_low, r_high;
    logic signed [wsdm_pkg::NEW-1:0]  r_ne;
    logic signed [wsdm_pkg::PW-1:0]   r_p1, r_p2;
    logic signed [wsdm_pkg::WW-1:0]   r_w [wsdm_pkg::P];
    logic [wsdm_pkg::WW-1:0]          r_range, r_x;
    logic [wsdm_pkg::QW-1:0]          r_q;
    logic [wsdm_pkg::QW-1:0]          r_desc [wsdm_pkg::P];
    logic [wsdm_pkg::QW-1:0]          r_ref [wsdm_pkg::P];
    logic                             r_refv;
    logic [2*wsdm_pkg::QW-1:0]        r_sq;
    logic [wsdm_pkg::ACCW-1:0]        r_acc;
    logic [1:0]                       r_status;
    logic                             r_match, r_mvalid;
    logic [wsdm_pkg::LW-1:0]          r_limit;

    logic                             w_store, w_room, w_short, w_last, w_ok_keep;
    logic [wsdm_pkg::CW-1:0]          w_nm1;
    logic [wsdm_pkg::IW+wsdm_pkg::AW-1:0] w_num;
    logic [wsdm_pkg::AW-1:0]          w_a, w_b, w_raddr;
    logic [wsdm_pkg::RW-1:0]          w_r;
    logic signed [wsdm_pkg::RW:0]     w_dmr, w_rs;
    logic [2*wsdm_pkg::CW-1:0]        w_nn;
    logic signed [wsdm_pkg::SUMW+wsdm_pkg::CW:0] w_sn;
    logic signed [wsdm_pkg::SW:0]     w_e;
    logic signed [wsdm_pkg::SW+wsdm_pkg::CW+1:0] w_ne;
    logic signed [wsdm_pkg::PW-1:0]   w_interp;
    logic signed [wsdm_pkg::KW+wsdm_pkg::PW:0] w_pk;
    logic signed [wsdm_pkg::IW+1:0]   w_ci;
    logic signed [wsdm_pkg::IW+wsdm_pkg::NEW+1:0] w_t3;
    logic signed [wsdm_pkg::WW-1:0]   w_new;
    logic [wsdm_pkg::WW:0]            w_x2, w_rng2;
    logic signed [wsdm_pkg::QW:0]     w_df;
    logic signed [2*wsdm_pkg::QW+1:0] w_sq;
    logic [wsdm_pkg::LIMW-1:0]        w_lim;

    assign w_store   = (i_cmd.op == wsdm_pkg::OP_STORE);
    assign w_room    = (r_count < wsdm_pkg::CW'(wsdm_pkg::MAX_WINDOW));
    assign w_short   = (r_count < wsdm_pkg::CW'(3));
    assign w_last    = (i_cmd.idx == wsdm_pkg::IW'(wsdm_pkg::P - 1));
    assign w_ok_keep = r_keep && (r_status == wsdm_pkg::STAT_OK);

    // Interpolation point: pos = idx*(n-1)/D, weights (D-r) and r.
    assign w_nm1  = r_count - 1'b1;
    assign w_num  = i_cmd.idx * w_nm1[wsdm_pkg::AW-1:0];
    assign w_a    = wsdm_pkg::AW'(w_num / wsdm_pkg::D);
    assign w_r    = wsdm_pkg::RW'(w_num % wsdm_pkg::D);
    assign w_b    = (w_r != '0) ? w_a + 1'b1 : w_a;
    assign w_raddr = (i_cmd.op == wsdm_pkg::OP_RDB) ? w_b : w_a;
    assign w_dmr  = $signed({1'b0, wsdm_pkg::RW'(wsdm_pkg::D) - w_r});
    assign w_rs   = $signed({1'b0, w_r});

    assign w_nn   = r_count * w_nm1;
    assign w_sn   = r_sum * $signed({1'b0, w_nm1});
    assign w_e    = r_lastx - r_first;
    assign w_ne   = w_e * $signed({1'b0, r_count});

    assign w_interp = r_p1 + r_p2;
    assign w_pk     = $signed({1'b0, r_k1}) * w_interp;
    assign w_ci     = $signed({1'b0, i_cmd.idx, 1'b0})
                      - $signed((wsdm_pkg::IW + 2)'(wsdm_pkg::D));
    assign w_t3     = w_ci * r_ne;
    assign w_new    = r_pk - r_c2 - r_t3;

    assign w_x2   = {r_x, 1'b0};
    assign w_rng2 = {1'b0, r_range};
    assign w_df   = $signed({1'b0, r_q}) - $signed({1'b0, r_ref[i_cmd.idx]});
    assign w_sq   = w_df * w_df;
    assign w_lim  = (wsdm_pkg::LIMW'(r_limit) * wsdm_pkg::LIMW'(wsdm_pkg::P))
                    << wsdm_pkg::QW;

    assign o_sts.cut  = r_ovf || w_short;
    assign o_sts.flat = (r_high == r_low);

    // Sample memory, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_store && w_room) mem[r_count[wsdm_pkg::AW-1:0]] <= i_sample;
        r_rd <= mem[w_raddr];
    end

    // Window and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_refv  <= 1'b0;
            r_limit <= wsdm_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (w_store) begin
                if (w_room) r_count <= r_count + 1'b1;
                else        r_ovf   <= 1'b1;
            end
            if (i_cmd.op == wsdm_pkg::OP_OUTW && w_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                if (w_ok_keep) r_refv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            wsdm_pkg::OP_STORE: begin
                r_keep <= i_keep_reference;
                if (w_room) begin
                    r_lastx <= i_sample;
                    if (r_count == '0) begin
                        r_first <= i_sample;
                        r_sum   <= wsdm_pkg::SUMW'(i_sample);
                    end else begin
                        r_sum   <= r_sum + wsdm_pkg::SUMW'(i_sample);
                    end
                end
            end
            wsdm_pkg::OP_CHECK: begin
                r_match  <= 1'b0;
                r_mvalid <= 1'b0;
                if (r_ovf)        r_status <= wsdm_pkg::STAT_LONG;
                else if (w_short) r_status <= wsdm_pkg::STAT_SHORT;
                else              r_status <= wsdm_pkg::STAT_OK;
            end
            wsdm_pkg::OP_PREP: begin
                r_k1  <= {w_nn, 1'b0};
                r_c2  <= wsdm_pkg::WW'(w_sn) * wsdm_pkg::WW'(2 * wsdm_pkg::D);
                r_ne  <= wsdm_pkg::NEW'(w_ne) * wsdm_pkg::NEW'(wsdm_pkg::D);
                r_acc <= '0;
            end
            wsdm_pkg::OP_RDB: begin
                r_xa <= r_rd;
            end
            wsdm_pkg::OP_MUL1: begin
                r_p1 <= wsdm_pkg::PW'(r_xa) * wsdm_pkg::PW'(w_dmr);
                r_p2 <= wsdm_pkg::PW'(r_rd) * wsdm_pkg::PW'(w_rs);
            end
            wsdm_pkg::OP_MUL2: begin
                r_pk <= w_pk[wsdm_pkg::WW-1:0];
                r_t3 <= w_t3[wsdm_pkg::WW-1:0];
            end
            wsdm_pkg::OP_WRW: begin
                r_w[i_cmd.idx] <= w_new;
                if (i_cmd.idx == '0 || w_new < r_low)  r_low  <= w_new;
                if (i_cmd.idx == '0 || w_new > r_high) r_high <= w_new;
            end
            wsdm_pkg::OP_RANGE: begin
                r_range <= r_high - r_low;
                if (r_high == r_low) r_status <= wsdm_pkg::STAT_FLAT;
            end
            wsdm_pkg::OP_NINIT: begin
                r_x <= r_w[i_cmd.idx] - r_low;
                r_q <= '0;
            end
            wsdm_pkg::OP_NSTEP: begin
                // One restoring-division step: one quotient bit per cycle.
                if (w_x2 >= w_rng2) begin
                    r_x <= wsdm_pkg::WW'(w_x2 - w_rng2);
                    r_q <= {r_q[wsdm_pkg::QW-2:0], 1'b1};
                end else begin
                    r_x <= w_x2[wsdm_pkg::WW-1:0];
                    r_q <= {r_q[wsdm_pkg::QW-2:0], 1'b0};
                end
            end
            wsdm_pkg::OP_SQ: begin
                r_desc[i_cmd.idx] <= r_q;
                r_sq <= w_sq[2*wsdm_pkg::QW-1:0];
            end
            wsdm_pkg::OP_ACC: begin
                r_acc <= r_acc + wsdm_pkg::ACCW'(r_sq);
            end
            wsdm_pkg::OP_MATCH: begin
                // The comparison uses the reference held before this window.
                if (r_refv) begin
                    r_match  <= (wsdm_pkg::LIMW'(r_acc) <= w_lim);
                    r_mvalid <= 1'b1;
                end
            end
            wsdm_pkg::OP_OUTW: begin
                if (w_ok_keep) r_ref[i_cmd.idx] <= r_desc[i_cmd.idx];
            end
            default: begin
            end
        endcase
    end

    assign o_descriptor  = (r_status == wsdm_pkg::STAT_OK) ? r_desc[i_cmd.idx] : '0;
    assign o_position    = 5'(i_cmd.idx);
    assign o_last_of_run = w_last;
    assign o_status      = r_status;
    assign o_match       = w_last && r_match;
    assign o_match_valid = w_last && r_mvalid;

endmodule

### rtl/core/window_shape_descriptor_match_core.sv
// Samples of a window are taken one word per cycle while o_stall is low. After the word
// marked last, input stalls while the sequencer works, mostly in the bit-serial normalizer
// for each of the 17 points and in reads through the single read port of the sample
// memory; a short or long window skips this. Then 17 result words go out, one per
// cycle when not stalled.
// Top level; depends on wsdm_pkg, wsdm_ctrl and wsdm_dp.
module window_shape_descriptor_match_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_sample,
    input  logic        i_last_sample,
    input  logic        i_keep_reference,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_descriptor,
    output logic [4:0]  o_position,
    output logic        o_last_of_run,
    output logic [1:0]  o_status,
    output logic        o_match,
    output logic        o_match_valid,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data
);

    wsdm_pkg::t_cmd w_cmd;
    wsdm_pkg::t_sts w_sts;

    wsdm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last_sample (i_last_sample),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    wsdm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_sample         ($signed(i_sample)),
        .i_keep_reference (i_keep_reference),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_descriptor     (o_descriptor),
        .o_position       (o_position),
        .o_last_of_run    (o_last_of_run),
        .o_status         (o_status),
        .o_match          (o_match),
        .o_match_valid    (o_match_valid)
    );

endmodule

### rtl/core/wsdm_checker.sv
// Port-level checks for window_shape_descriptor_match_core, and the bind
// that attaches them. Depends on the top level's ports and wsdm_pkg.
module wsdm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_descriptor,
    input logic        o_last_of_run,
    input logic [1:0]  o_status,
    input logic        o_match,
    input logic        o_match_valid
);

    // No sample is taken while results are being delivered.
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open during output");

    // The run ends after its last word is taken.
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_run && !i_stall) |=> !o_valid)
        else $error("output continues after last word");

    // Match flags only appear on the last word.
    a_match_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> (!o_match && !o_match_valid))
        else $error("match flag on non-last word");

    // A flagged window carries zero descriptors and no match.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != wsdm_pkg::STAT_OK)
            |-> (o_descriptor == 16'd0 && !o_match_valid))
        else $error("flagged window with data");

endmodule

bind window_shape_descriptor_match_core wsdm_checker u_wsdm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_descriptor  (o_descriptor),
    .o_last_of_run (o_last_of_run),
    .o_status      (o_status),
    .o_match       (o_match),
    .o_match_valid (o_match_valid)
);
